### hw/rtl/mcg_pkg.sv
package mcg_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COL_W    = 3;
    localparam int ROW_W    = 3;
    localparam int P_W      = 15;
    localparam int TOT_W    = 16;
    localparam int PROD_W   = 28;
    localparam int QUOT_W   = 8;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2**15
    localparam logic [13:0] RECIP_100   = 14'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [P_W-1:0] YEAR_BIAS = 15'd399;
    localparam logic [6:0] CENTURY = 7'd100;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [COL_W-1:0]   SATURDAY  = 3'd6;

    typedef struct packed {
        logic [COL_W-1:0] start;
        logic [DAY_W-1:0] ndays;
    } mcg_setup_t;

    // days before the month, mod 7, common year
    function automatic logic [COL_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [COL_W-1:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                    r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

    // value below 21 reduced mod 7
    function automatic logic [COL_W-1:0] mod7_small(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd14)
            r = v - 5'd14;
        else if (v >= 5'd7)
            r = v - 5'd7;
        else
            r = v;
        return r[COL_W-1:0];
    endfunction

endpackage

### hw/rtl/mcg_setup.sv
module mcg_setup
    import mcg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    output logic                out_valid,
    input  logic                out_ready,
    output mcg_setup_t          setup
);

    logic adv1, adv2, adv3;
    logic month_ok;

    logic                v1_reg;
    logic [P_W-1:0]      p1_reg;
    logic [YEAR_W-1:0]   y1_reg;
    logic [MONTH_W-1:0]  m1_reg;
    logic [PROD_W-1:0]   prodp1_reg;
    logic [PROD_W-1:0]   prody1_reg;

    logic                v2_reg;
    logic [TOT_W-1:0]    tot2_reg;
    logic                leap2_reg;
    logic [MONTH_W-1:0]  m2_reg;

    logic                v3_reg;
    mcg_setup_t          s3_reg;

    logic [P_W-1:0]      p_next;
    logic [QUOT_W-1:0]   qp, qy;
    logic [TOT_W-1:0]    tot_next;
    logic [YEAR_W-1:0]   qy_times;
    logic                leap_next;
    logic [5:0]          dsum;
    logic [3:0]          fold;
    logic [4:0]          wsum;
    mcg_setup_t          s3_next;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);

    // stage 1: year + 399 and the two reciprocal products
    assign p_next = {1'b0, year} + YEAR_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv1)
            v1_reg <= in_valid && month_ok;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            p1_reg     <= p_next;
            y1_reg     <= year;
            m1_reg     <= month;
            prodp1_reg <= PROD_W'(p_next) * PROD_W'(RECIP_100);
            prody1_reg <= PROD_W'(year) * PROD_W'(RECIP_100);
        end
    end

    // stage 2: day count mod-7 equivalent and leap test
    always_comb
    begin
        qp        = prodp1_reg[RECIP_SHIFT +: QUOT_W];
        qy        = prody1_reg[RECIP_SHIFT +: QUOT_W];
        tot_next  = TOT_W'(p1_reg) + TOT_W'(p1_reg >> 2) - TOT_W'(qp)
                    + TOT_W'(qp >> 2) + TOT_W'(1);
        qy_times  = YEAR_W'(qy) * YEAR_W'(CENTURY);
        leap_next = (y1_reg[1:0] == 2'b00) &&
                    ((qy_times != y1_reg) || (qy[1:0] == 2'b00));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            tot2_reg  <= tot_next;
            leap2_reg <= leap_next;
            m2_reg    <= m1_reg;
        end
    end

    // stage 3: mod 7 by octal digit sum, month offset, month length
    always_comb
    begin
        dsum = 6'(tot2_reg[2:0]) + 6'(tot2_reg[5:3]) + 6'(tot2_reg[8:6])
               + 6'(tot2_reg[11:9]) + 6'(tot2_reg[14:12]) + 6'(tot2_reg[15]);
        fold = 4'(dsum[5:3]) + 4'(dsum[2:0]);
        wsum = 5'(fold) + 5'(month_offset(m2_reg))
               + 5'(leap2_reg && (m2_reg > MONTH_FEB));
        s3_next.start = mod7_small(wsum);
        s3_next.ndays = month_days(m2_reg, leap2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
            s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign setup     = s3_reg;

endmodule

### hw/rtl/mcg_emit.sv
module mcg_emit
    import mcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mcg_setup_t        setup,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DAY_W-1:0]  day_of_month,
    output logic [COL_W-1:0]  weekday_column,
    output logic [ROW_W-1:0]  grid_row,
    output logic              last_day
);

    logic              busy_reg;
    logic [DAY_W-1:0]  day_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [DAY_W-1:0]  nd_reg;

    logic              ov_reg;
    logic [DAY_W-1:0]  oday_reg;
    logic [COL_W-1:0]  ocol_reg;
    logic [ROW_W-1:0]  orow_reg;
    logic              olast_reg;

    logic              load, fire, is_last;
    logic [COL_W-1:0]  col_next;

    assign in_ready = !busy_reg;
    assign load     = in_valid && !busy_reg;
    assign fire     = busy_reg && (!ov_reg || out_ready);
    assign is_last  = (day_reg == nd_reg);
    assign col_next = (col_reg == SATURDAY) ? '0 : col_reg + COL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (load)
                busy_reg <= 1'b1;
            else if (fire && is_last)
                busy_reg <= 1'b0;
            if (fire)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            day_reg <= DAY_W'(1);
            col_reg <= setup.start;
            row_reg <= '0;
            nd_reg  <= setup.ndays;
        end
        else if (fire)
        begin
            day_reg <= day_reg + DAY_W'(1);
            col_reg <= col_next;
            row_reg <= row_reg + ROW_W'(col_next == '0);
        end
        if (fire)
        begin
            oday_reg  <= day_reg;
            ocol_reg  <= col_reg;
            orow_reg  <= row_reg;
            olast_reg <= is_last;
        end
    end

    assign out_valid      = ov_reg;
    assign day_of_month   = oday_reg;
    assign weekday_column = ocol_reg;
    assign grid_row       = orow_reg;
    assign last_day       = olast_reg;

endmodule

### hw/rtl/month_calendar_grid.sv
// Month grid generator: each input item (year, month) yields one output item
// per day of that month, in day order, with the weekday column (0 Sunday),
// the row in a six-row grid and tlast on the final day. A month of 0 or above
// 12 yields nothing. Weekday setup runs in a three-stage pipeline; the day
// emitter then sends one day per cycle unless m_axis_tready stalls it, and loads
// the next month only after the last day of the current one; the setup pipeline
// latency is hidden behind the previous month.
module month_calendar_grid
    import mcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // year[13:0], month[17:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // day_of_month[4:0], weekday_column[7:5], grid_row[10:8]
    output logic        m_axis_tlast    // last_day
);

    logic              setup_valid, setup_ready;
    mcg_setup_t        setup;
    logic [DAY_W-1:0]  day_of_month;
    logic [COL_W-1:0]  weekday_column;
    logic [ROW_W-1:0]  grid_row;

    mcg_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .year      (s_axis_tdata[YEAR_W-1:0]),
        .month     (s_axis_tdata[YEAR_W +: MONTH_W]),
        .out_valid (setup_valid),
        .out_ready (setup_ready),
        .setup     (setup)
    );

    mcg_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (setup_valid),
        .in_ready       (setup_ready),
        .setup          (setup),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .day_of_month   (day_of_month),
        .weekday_column (weekday_column),
        .grid_row       (grid_row),
        .last_day       (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, grid_row, weekday_column, day_of_month};

endmodule

### verif/month_calendar_grid_tb.sv
`timescale 1ns / 1ps

module month_calendar_grid_tb;
    import mcg_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } day_cell_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // year[13:0], month[17:14]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // day_of_month[4:0], weekday_column[7:5], grid_row[10:8]
    logic        m_axis_tlast;        // last_day

    day_cell_t   expected_days[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_hold = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;

    month_calendar_grid dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_of(input int unsigned m, input int unsigned y);
        int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == MONTH_FEB)
            return leap_year(y) ? 29 : 28;
        return lens[m - 1];
    endfunction

    // Expected grid cells for one accepted (year, month) item.
    task automatic queue_month_days(input logic [YEAR_W-1:0] year,
                                    input logic [MONTH_W-1:0] month);
        int unsigned y;
        int unsigned p;
        int unsigned total;
        int unsigned start;
        int unsigned ndays;
        int unsigned col;
        int unsigned row;
        day_cell_t   day_entry;
        y = year;
        if (month < MONTH_JAN || month > MONTH_DEC)
            return;
        // shift by 400 years: same weekdays, no underflow for year 0
        p = y + 399;
        total = 365 * p + p / 4 - p / 100 + p / 400;
        start = (total + 1) % 7;
        for (int unsigned m = 1; m < month; m++)
            start = (start + days_of(m, y)) % 7;
        ndays = days_of(month, y);
        row = 0;
        for (int unsigned k = 1; k <= ndays; k++)
        begin
            col = (start + k - 1) % 7;
            if (k > 7 - start && col == 0)
                row++;
            day_entry.day  = k[DAY_W-1:0];
            day_entry.col  = col[COL_W-1:0];
            day_entry.row  = row[ROW_W-1:0];
            day_entry.last = (k == ndays);
            expected_days.push_back(day_entry);
        end
    endtask

    // Sink: may stall for a random time after each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= 0;
        end
        else if (m_axis_tready)
        begin
            if (m_axis_tvalid)
            begin
                int unsigned n;
                n = sink_idle_en ? $urandom_range(0, 4) : 0;
                if (n != 0)
                begin
                    m_axis_tready <= 1'b0;
                    sink_hold     <= n - 1;
                end
            end
        end
        else if (sink_hold != 0)
            sink_hold <= sink_hold - 1;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            day_cell_t exp_cell;
            day_cell_t got_cell;
            got_cell.day  = m_axis_tdata[4:0];
            got_cell.col  = m_axis_tdata[7:5];
            got_cell.row  = m_axis_tdata[10:8];
            got_cell.last = m_axis_tlast;
            if (expected_days.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected item day=%0d col=%0d row=%0d last=%0b",
                             got_cell.day, got_cell.col, got_cell.row, got_cell.last);
            end
            else
            begin
                exp_cell = expected_days.pop_front();
                if (got_cell !== exp_cell)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"ERROR: exp day=%0d col=%0d row=%0d last=%0b, ",
                                  "got day=%0d col=%0d row=%0d last=%0b"},
                                 exp_cell.day, exp_cell.col, exp_cell.row, exp_cell.last,
                                 got_cell.day, got_cell.col, got_cell.row, got_cell.last);
                end
            end
        end
    end

    // Called at a rising edge; valid stays high across back-to-back items.
    task automatic send_item(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, month, year};
        do
            @(posedge clk);
        while (!s_axis_tready);
        queue_month_days(year, month);
    endtask

    task automatic test_month_lengths();
        for (int m = 1; m <= 12; m++)
            send_item(14'd2024, m[MONTH_W-1:0]);
    endtask

    task automatic test_leap_rules();
        send_item(14'd2000, MONTH_FEB);
        send_item(14'd1900, MONTH_FEB);
        send_item(14'd2023, MONTH_FEB);
        send_item(14'd0, MONTH_FEB);
    endtask

    // year 0 and years past 9999 follow the same rules
    task automatic test_year_extremes();
        send_item(14'd0, MONTH_JAN);
        send_item(14'd1, MONTH_JAN);
        send_item(14'd9999, MONTH_DEC);
        send_item(14'h3FFF, MONTH_DEC);
    endtask

    task automatic test_bad_months();
        send_item(14'd2024, 4'd0);
        send_item(14'h3FFF, 4'd13);
        send_item(14'd0, 4'd14);
        send_item(14'd1999, 4'd15);
    endtask

    task automatic test_random_months(input int unsigned count);
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        int unsigned        pick;
        int unsigned        centuries[6] = '{0, 100, 400, 1600, 1900, 2000};
        for (int unsigned i = 0; i < count; i++)
        begin
            src_idle_en  = ((i / 30) % 3) != 2;
            sink_idle_en = ((i / 20) % 4) != 3;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                year = YEAR_W'($urandom_range(1, 9999));
            else if (pick < 9)
                year = YEAR_W'($urandom_range(0, 16383));
            else
                year = YEAR_W'(centuries[$urandom_range(0, 5)] + 400 * $urandom_range(0, 20));
            if ($urandom_range(0, 9) == 0)
                month = MONTH_W'($urandom_range(0, 15));
            else
                month = MONTH_W'($urandom_range(1, 12));
            send_item(year, month);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_month_lengths();
        test_leap_rules();
        test_year_extremes();
        test_bad_months();
        test_random_months(156);

        s_axis_tvalid <= 1'b0;
        sink_idle_en = 1'b1;
        while (expected_days.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
